@@ rtl/ssdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdp_pkg
// Shared types and field widths for the step/direction pulse generator.
// ----------------------------------------------------------------------------
package ssdp_pkg;

    localparam int COUNT_W = 32;
    localparam int DELAY_W = 16;
    localparam int WAIT_W  = DELAY_W + 1;
    localparam int IN_W    = COUNT_W + DELAY_W;
    localparam int OUT_W   = 72;

    typedef enum logic
    {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [DELAY_W-1:0] delay_ticks;
        logic signed [COUNT_W-1:0] step_count;
        op_t                op;
    } item_t;

    typedef struct packed
    {
        logic signed [COUNT_W-1:0] steps_left;
        logic                      moving;
        logic signed [COUNT_W-1:0] position;
        logic                      asleep;
        logic                      forward;
        logic                      step_level;
    } result_t;

endpackage

@@ rtl/ssdp_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdp_in_reg
// Input register: holds one command or tick word until the sequencer takes it.
// ----------------------------------------------------------------------------
module ssdp_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ssdp_pkg::item_t in_item,
    output logic           held_valid,
    input  logic           advance,
    output ssdp_pkg::item_t held_item
);
    import ssdp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/ssdp_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdp_seq
// Pulse sequencer: state registers and the per-word next-state logic.
// ----------------------------------------------------------------------------
module ssdp_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ssdp_pkg::item_t   item,
    output ssdp_pkg::result_t result
);
    import ssdp_pkg::*;

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_ARMED,
        PH_HIGH,
        PH_WAIT
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               sleep_reg, sleep_next;
    logic               dir_reg, dir_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    logic               pulse_reg, pulse_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [WAIT_W-1:0]  wait_inc;

    assign wait_inc = wait_reg + WAIT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        sleep_next = sleep_reg;
        dir_next   = dir_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        wait_next  = wait_reg;
        pulse_next = pulse_reg;
        delay_next = delay_reg;
        if (item.op == OP_START)
        begin
            rem_next   = item.step_count;
            delay_next = item.delay_ticks;
            phase_next = PH_ARMED;
        end
        else
        begin
            unique case (phase_reg)
                PH_ARMED:
                begin
                    if (rem_reg == '0)
                    begin
                        // empty move: straight back to sleep
                        pulse_next = 1'b0;
                        sleep_next = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        sleep_next = 1'b0;
                        dir_next   = !rem_reg[COUNT_W-1];
                        wait_next  = '0;
                        pulse_next = 1'b1;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    pulse_next = 1'b0;
                    if (rem_reg != '0 && !rem_reg[COUNT_W-1])
                    begin
                        rem_next = rem_reg - COUNT_W'(1);
                        pos_next = pos_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        rem_next = rem_reg + COUNT_W'(1);
                        pos_next = pos_reg - COUNT_W'(1);
                    end
                    if (rem_next == '0)
                    begin
                        sleep_next = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    wait_next = wait_inc;
                    if (wait_inc > {1'b0, delay_reg})
                    begin
                        wait_next  = '0;
                        pulse_next = 1'b1;
                        phase_next = PH_HIGH;
                    end
                end
                PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sleep_reg <= 1'b1;
            dir_reg   <= 1'b1;
            pos_reg   <= '0;
            rem_reg   <= '0;
            wait_reg  <= '0;
            pulse_reg <= 1'b0;
            delay_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            sleep_reg <= sleep_next;
            dir_reg   <= dir_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            wait_reg  <= wait_next;
            pulse_reg <= pulse_next;
            delay_reg <= delay_next;
        end
    end

    // result word reflects the state after this word
    always_comb
    begin
        result.step_level = pulse_next;
        result.forward    = dir_next;
        result.asleep     = sleep_next;
        result.position   = pos_next;
        result.moving     = (phase_next != PH_IDLE);
        result.steps_left = rem_next;
    end

endmodule

@@ rtl/ssdp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdp_out_reg
// Result register: holds a finished word until the downstream side takes it.
// ----------------------------------------------------------------------------
module ssdp_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              held_valid,
    input  ssdp_pkg::result_t result,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output ssdp_pkg::result_t out_result
);
    import ssdp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance    = held_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (advance)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ rtl/stepper_step_dir_pulse_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_step_dir_pulse_generator
// Step/direction pulse sequencer for a stepper driver, one status word per
// tick or start command.
// ----------------------------------------------------------------------------
// Each input word is a timer tick or a start command; each one produces exactly
// one status word giving step pin, direction pin, sleep pin, position, moving
// flag and remaining steps after that word. A word passes through the input
// register, then the sequencer update into the result register, and one word
// is accepted every cycle while the output side keeps up; a full result
// register holds off the input only when the downstream side stalls.
module stepper_step_dir_pulse_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] step_count, [47:32] delay_ticks
    input  logic [47:0] s_tdata,
    // [0] op
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] step_level, [1] forward, [2] asleep, [34:3] position, [35] moving,
    // [67:36] steps_left, [71:68] zero
    output logic [71:0] m_tdata
);
    import ssdp_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    result_t result;
    result_t out_result;

    assign in_item.op          = op_t'(s_tuser);
    assign in_item.step_count  = s_tdata[COUNT_W-1:0];
    assign in_item.delay_ticks = s_tdata[IN_W-1:COUNT_W];

    ssdp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .advance    (advance),
        .held_item  (held_item)
    );

    ssdp_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (result)
    );

    ssdp_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {(OUT_W - $bits(result_t))'(0), out_result};

endmodule

@@ rtl/ssdp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdp_checker
// Port-level checks for the step/direction pulse generator.
// ----------------------------------------------------------------------------
module ssdp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata
);

    logic out_step;
    logic out_asleep;
    logic out_moving;
    logic in_seen;

    assign out_step   = m_tdata[0];
    assign out_asleep = m_tdata[2];
    assign out_moving = m_tdata[35];
    assign in_seen    = s_tvalid && s_tready && (s_tuser || !s_tuser) && (s_tdata == s_tdata);

    // idle means driver asleep and step pin low
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_moving |-> out_asleep && !out_step)
        else $error("idle word with driver awake or step pin high");

    // an empty output side never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // nothing can appear at the output without an earlier accepted word
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_seen, 2) || $past(in_seen, 1) || $past(!s_tready))
        else $error("output word with no input word behind it");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

endmodule

bind stepper_step_dir_pulse_generator ssdp_checker u_ssdp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/ssdp_status_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdp_status_checker
// Watches both stream channels of the pulse generator. It runs its own model
// of the step sequencer on every accepted input word and compares each status
// word, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module ssdp_status_checker
    import ssdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [31:0] step_count, [47:32] delay_ticks
    input  logic [47:0] s_tdata,
    // [0] op
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [0] step_level, [1] forward, [2] asleep, [34:3] position, [35] moving,
    // [67:36] steps_left, [71:68] zero
    input  logic [71:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef enum logic [1:0]
    {
        SEQ_IDLE,
        SEQ_ARMED,
        SEQ_HIGH,
        SEQ_WAIT
    } seq_phase_t;

    seq_phase_t          seq_phase;
    logic                sleeping;
    logic                dir_fwd;
    logic [COUNT_W-1:0]  cur_pos;
    logic [COUNT_W-1:0]  steps_rem;
    logic [WAIT_W-1:0]   wait_cnt;
    logic                pin_level;
    logic [DELAY_W-1:0]  gap_len;

    result_t             expected_status[$];

    task automatic reset_sequencer();
        seq_phase = SEQ_IDLE;
        sleeping  = 1'b1;
        dir_fwd   = 1'b1;
        cur_pos   = '0;
        steps_rem = '0;
        wait_cnt  = '0;
        pin_level = 1'b0;
        gap_len   = '0;
    endtask

    task automatic advance_sequencer(input op_t op, input logic [COUNT_W-1:0] cnt,
                                     input logic [DELAY_W-1:0] dly, output result_t r);
        if (op == OP_START)
        begin
            // new move drops any running one, pins untouched until next tick
            steps_rem = cnt;
            gap_len   = dly;
            seq_phase = SEQ_ARMED;
        end
        else
        begin
            case (seq_phase)
                SEQ_ARMED:
                begin
                    if (steps_rem == '0)
                    begin
                        pin_level = 1'b0;
                        sleeping  = 1'b1;
                        seq_phase = SEQ_IDLE;
                    end
                    else
                    begin
                        sleeping  = 1'b0;
                        dir_fwd   = ~steps_rem[COUNT_W-1];
                        wait_cnt  = '0;
                        pin_level = 1'b1;
                        seq_phase = SEQ_HIGH;
                    end
                end
                SEQ_HIGH:
                begin
                    pin_level = 1'b0;
                    if (steps_rem != '0 && !steps_rem[COUNT_W-1])
                    begin
                        steps_rem = steps_rem - COUNT_W'(1);
                        cur_pos   = cur_pos + COUNT_W'(1);
                    end
                    else
                    begin
                        steps_rem = steps_rem + COUNT_W'(1);
                        cur_pos   = cur_pos - COUNT_W'(1);
                    end
                    if (steps_rem == '0)
                    begin
                        sleeping  = 1'b1;
                        seq_phase = SEQ_IDLE;
                    end
                    else
                    begin
                        seq_phase = SEQ_WAIT;
                    end
                end
                SEQ_WAIT:
                begin
                    wait_cnt = wait_cnt + WAIT_W'(1);
                    if (wait_cnt > {1'b0, gap_len})
                    begin
                        wait_cnt  = '0;
                        pin_level = 1'b1;
                        seq_phase = SEQ_HIGH;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.step_level = pin_level;
        r.forward    = dir_fwd;
        r.asleep     = sleeping;
        r.position   = cur_pos;
        r.moving     = (seq_phase != SEQ_IDLE);
        r.steps_left = steps_rem;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name,
                     exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            reset_sequencer();
            expected_status.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            // drain first: a status word can never belong to an input of this edge
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[67:0];
                if (expected_status.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: status word with none expected, got %h", $time,
                             m_tdata);
                end
                else
                begin
                    want = expected_status.pop_front();
                    checked++;
                    check_field("step_level", 32'(want.step_level), 32'(got.step_level));
                    check_field("forward", 32'(want.forward), 32'(got.forward));
                    check_field("asleep", 32'(want.asleep), 32'(got.asleep));
                    check_field("position", want.position, got.position);
                    check_field("moving", 32'(want.moving), 32'(got.moving));
                    check_field("steps_left", want.steps_left, got.steps_left);
                    check_field("pad bits", 32'd0, {28'd0, m_tdata[71:68]});
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_sequencer(op_t'(s_tuser), s_tdata[31:0], s_tdata[47:32], want);
                expected_status.push_back(want);
            end
            pending = expected_status.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the step/direction pulse generator. Directed words
// hit the edge cases, then random move sequences with ticks, preempting starts
// and noise run with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module testbench;
    import ssdp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1800;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    int          fail_count;
    int          pending;
    int          checked;
    int          words_sent;
    int          starts_sent;
    int          burst_left;
    int          cycles;

    stepper_step_dir_pulse_generator i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ssdp_status_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d status words outstanding", cycles,
                         pending);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // output side stalls in stretches of changing character
    initial
    begin
        int mode;
        int stretch;
        int run;
        m_tready = 1'b0;
        mode     = 0;
        stretch  = 0;
        run      = 0;
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                2: m_tready <= ($urandom_range(0, 9) < 3);
                default:
                begin
                    if (run == 0)
                    begin
                        m_tready <= ~m_tready;
                        run = $urandom_range(1, 12);
                    end
                    run--;
                end
            endcase
        end
    end

    task automatic send_word(input op_t op, input logic [31:0] cnt, input logic [15:0] dly);
        int gap;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dly, cnt};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
        words_sent++;
        if (op == OP_START)
        begin
            starts_sent++;
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(OP_TICK, $urandom, 16'($urandom));
    endtask

    // ticks from the start until the move has gone idle again, plus one spare tick per step
    function automatic int ticks_to_finish(input int n, input int dly);
        int mag;
        mag = (n < 0) ? -n : n;
        if (mag == 0)
        begin
            return 1;
        end
        return 1 + 2 * mag + (mag - 1) * (dly + 1);
    endfunction

    initial
    begin
        int sel;
        int n;
        int dly;
        int need;
        int ticks;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_TICK;
        rst_n       = 1'b0;
        words_sent  = 0;
        starts_sent = 0;
        burst_left  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tick while idle, then a zero-step move
        send_ticks(2);
        send_word(OP_START, 32'd0, 16'd0);
        send_ticks(2);
        // one step forward; with a single pulse the maximum delay is never waited out
        send_word(OP_START, 32'd1, 16'hffff);
        send_ticks(3);
        // two steps backward with a one-tick extra gap
        send_word(OP_START, 32'hffff_fffe, 16'd1);
        send_ticks(ticks_to_finish(-2, 1));
        // extreme counts: the first preempted while waiting, the second while the pin is high
        send_word(OP_START, 32'h7fff_ffff, 16'hffff);
        send_ticks(3);
        send_word(OP_START, 32'h8000_0000, 16'd0);
        send_ticks(1);
        send_word(OP_START, 32'd3, 16'd0);
        send_word(OP_START, 32'd2, 16'd0);
        send_ticks(ticks_to_finish(2, 0) + 1);

        while (words_sent < RANDOM_WORDS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                n   = int'($urandom_range(0, 12)) - 6;
                dly = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(4, 40);
                need = ticks_to_finish(n, dly);
                ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, need)
                                                    : need + $urandom_range(0, 3);
                send_word(OP_START, n, 16'(dly));
                send_ticks(ticks);
            end
            else if (sel < 85)
            begin
                send_ticks($urandom_range(1, 6));
            end
            else
            begin
                // wide values; big delays never finish, the next start cuts them off
                if ($urandom_range(0, 1) == 0)
                begin
                    send_word(OP_START, $urandom, 16'($urandom));
                end
                else
                begin
                    send_word(OP_START, ($urandom_range(0, 1) != 0) ? 32'd1 : 32'hffff_ffff,
                              16'($urandom));
                end
                send_ticks($urandom_range(0, 10));
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("sent %0d words (%0d move starts), checked %0d status words", words_sent,
                 starts_sent, checked);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("%0d mismatches, %0d status words outstanding", fail_count, pending);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ssdp_pkg.sv
rtl/ssdp_in_reg.sv
rtl/ssdp_seq.sv
rtl/ssdp_out_reg.sv
rtl/stepper_step_dir_pulse_generator.sv
rtl/ssdp_checker.sv
dv/ssdp_status_checker.sv
dv/testbench.sv
